// File: rtl/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared constants, codes and the heap entry type for the k-way merge heap.
// ----------------------------------------------------------------------------
package kwm_pkg;

	localparam int NUM_SOURCES = 16;
	localparam int VALUE_BITS  = 32;
	localparam int SRC_BITS    = $clog2(NUM_SOURCES);
	localparam int IDX_BITS    = $clog2(NUM_SOURCES);
	localparam int CNT_BITS    = $clog2(NUM_SOURCES + 1);
	localparam int CHILD_BITS  = IDX_BITS + 2;

	localparam logic [1:0] MODE_INSERT  = 2'd0;
	localparam logic [1:0] MODE_POP     = 2'd1;
	localparam logic [1:0] MODE_REPLACE = 2'd2;

	localparam logic [1:0] ST_EMITTED = 2'd0;
	localparam logic [1:0] ST_INSERTED = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] value;
		logic        [SRC_BITS-1:0]   source;
	} entry_t;

endpackage

// File: rtl/kwm_if.sv
// ----------------------------------------------------------------------------
// kwm_if
// Command and response channels of the merge heap, valid/ready per word.
// ----------------------------------------------------------------------------
interface kwm_cmd_if import kwm_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic [1:0]                   mode;
	logic signed [VALUE_BITS-1:0] value;
	logic [SRC_BITS-1:0]          src;

	modport source (output valid, output mode, output value, output src, input ready);
	modport sink   (input valid, input mode, input value, input src, output ready);
endinterface

interface kwm_rsp_if import kwm_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] out_value;
	logic [SRC_BITS-1:0]          out_source;
	logic [1:0]                   status;
	logic [CNT_BITS-1:0]          occupancy;

	modport source (output valid, output out_value, output out_source, output status,
		output occupancy, input ready);
	modport sink   (input valid, input out_value, input out_source, input status,
		input occupancy, output ready);
endinterface

// File: rtl/k_way_merge_min_heap_unit.sv
// ----------------------------------------------------------------------------
// k_way_merge_min_heap_unit
// Binary min-heap of source heads in one synchronous RAM, hole-based sifting.
// ----------------------------------------------------------------------------
//  channel | dir | words
//  cmd     | in  | mode, value, src
//  rsp     | out | out_value, out_source, status, occupancy
//
//  One command at a time. Insert: compare and write-back, then a parent read
//  and compare / write-back per level climbed. Pop / replace: root read, then
//  per level descended a RAM read of both children then a compare and
//  write-back. Full insert or empty pop goes straight to the response.
//  Reset empties the heap at once; RAM contents are never cleared.
//  rsp stalls hold the result; cmd is not taken until it is delivered.
// ----------------------------------------------------------------------------
module k_way_merge_min_heap_unit import kwm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	kwm_cmd_if.sink   cmd,
	kwm_rsp_if.source rsp
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SU_RD  = 3'd1;
	localparam logic [2:0] S_SU_CMP = 3'd2;
	localparam logic [2:0] S_POP_LD = 3'd3;
	localparam logic [2:0] S_SD_RD  = 3'd4;
	localparam logic [2:0] S_SD_CMP = 3'd5;
	localparam logic [2:0] S_OUT    = 3'd6;

	entry_t mem [NUM_SOURCES];
	entry_t rd_a_q, rd_b_q;

	logic [2:0]                   state_q;
	logic [CNT_BITS-1:0]          cnt_q;
	logic [IDX_BITS-1:0]          pos_q;
	entry_t                       x_q;
	logic                         replace_q;
	logic signed [VALUE_BITS-1:0] val_q;
	logic signed [VALUE_BITS-1:0] res_value_q;
	logic [SRC_BITS-1:0]          res_source_q;
	logic [1:0]                   res_status_q;

	logic                  accept, is_insert;
	logic                  we;
	logic [IDX_BITS-1:0]   wa, ra_a, ra_b, parent, cnt_idx, last_idx;
	entry_t                wd;
	logic [CHILD_BITS-1:0] left, right;
	logic                  lv, rv;
	logic                  x_first, lx, rx, rl;
	logic                  take_l, take_r;

	assign accept    = cmd.valid && cmd.ready;
	assign is_insert = (cmd.mode == MODE_INSERT);
	assign cnt_idx   = cnt_q[IDX_BITS-1:0];
	assign last_idx  = IDX_BITS'(cnt_q - CNT_BITS'(1));
	assign parent    = IDX_BITS'((pos_q - IDX_BITS'(1)) >> 1);
	assign left      = CHILD_BITS'({pos_q, 1'b1});
	assign right     = left + CHILD_BITS'(1);
	assign lv        = (left < CHILD_BITS'(cnt_q));
	assign rv        = (right < CHILD_BITS'(cnt_q));

	kwm_order u_xa (.a(x_q),    .b(rd_a_q), .first(x_first));
	kwm_order u_lx (.a(rd_a_q), .b(x_q),    .first(lx));
	kwm_order u_rx (.a(rd_b_q), .b(x_q),    .first(rx));
	kwm_order u_rl (.a(rd_b_q), .b(rd_a_q), .first(rl));

	assign take_l = lv && lx;
	assign take_r = rv && (take_l ? rl : rx);

	always_comb begin
		we   = 1'b0;
		wa   = pos_q;
		wd   = x_q;
		ra_a = '0;
		ra_b = last_idx;
		case (state_q)
			S_IDLE: begin
				ra_a = is_insert
					? IDX_BITS'((cnt_idx - IDX_BITS'(1)) >> 1) : '0;
			end
			S_SU_RD: begin
				ra_a = parent;
			end
			S_SU_CMP: begin
				we = 1'b1;
				if (pos_q != '0 && x_first) begin
					wd = rd_a_q;
				end
			end
			S_SD_RD: begin
				ra_a = left[IDX_BITS-1:0];
				ra_b = right[IDX_BITS-1:0];
			end
			S_SD_CMP: begin
				we = 1'b1;
				if (take_r) begin
					wd = rd_b_q;
				end else if (take_l) begin
					wd = rd_a_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_a_q <= mem[ra_a];
		rd_b_q <= mem[ra_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						replace_q <= (cmd.mode == MODE_REPLACE);
						val_q     <= cmd.value;
						pos_q     <= cnt_idx;
						x_q       <= '{value: cmd.value, source: cmd.src};
						if (is_insert) begin
							res_value_q  <= '0;
							res_source_q <= cmd.src;
							if (cnt_q >= CNT_BITS'(NUM_SOURCES)) begin
								res_status_q <= ST_FULL;
								state_q      <= S_OUT;
							end else begin
								res_status_q <= ST_INSERTED;
								cnt_q        <= cnt_q + CNT_BITS'(1);
								state_q      <= S_SU_CMP;
							end
						end else if (cnt_q == '0) begin
							res_value_q  <= '0;
							res_source_q <= '0;
							res_status_q <= ST_EMPTY;
							state_q      <= S_OUT;
						end else begin
							res_status_q <= ST_EMITTED;
							if (cmd.mode != MODE_REPLACE) begin
								cnt_q <= cnt_q - CNT_BITS'(1);
							end
							state_q <= S_POP_LD;
						end
					end
				end
				S_SU_RD: begin
					state_q <= S_SU_CMP;
				end
				S_SU_CMP: begin
					if (pos_q != '0 && x_first) begin
						pos_q   <= parent;
						state_q <= S_SU_RD;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_POP_LD: begin
					res_value_q  <= rd_a_q.value;
					res_source_q <= rd_a_q.source;
					x_q          <= replace_q
						? '{value: val_q, source: rd_a_q.source} : rd_b_q;
					pos_q        <= '0;
					state_q      <= S_SD_RD;
				end
				S_SD_RD: begin
					state_q <= S_SD_CMP;
				end
				S_SD_CMP: begin
					if (take_r) begin
						pos_q   <= right[IDX_BITS-1:0];
						state_q <= S_SD_RD;
					end else if (take_l) begin
						pos_q   <= left[IDX_BITS-1:0];
						state_q <= S_SD_RD;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cmd.ready      = (state_q == S_IDLE);
	assign rsp.valid      = (state_q == S_OUT);
	assign rsp.out_value  = res_value_q;
	assign rsp.out_source = res_source_q;
	assign rsp.status     = res_status_q;
	assign rsp.occupancy  = cnt_q;

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_BITS'(NUM_SOURCES))
		else $error("entry count above capacity");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_FULL |-> rsp.occupancy == CNT_BITS'(NUM_SOURCES))
		else $error("full status with spare room");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_EMPTY |-> rsp.occupancy == '0)
		else $error("empty status with entries held");

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !cmd.ready)
		else $error("command taken while one is in flight");
`endif

endmodule

// File: rtl/kwm_order.sv
// ----------------------------------------------------------------------------
// kwm_order
// Heap ordering: signed value first, then the smaller source index.
// ----------------------------------------------------------------------------
module kwm_order import kwm_pkg::*; (
	input  entry_t a,
	input  entry_t b,
	output logic   first
);

	always_comb begin
		if (a.value != b.value) begin
			first = (a.value < b.value);
		end else begin
			first = (a.source < b.source);
		end
	end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the k-way merge min-heap unit. Commands go in on a
// bursty valid/ready channel, and an in-bench heap predicts every response
// word. Responses are compared field by field against a queue of expected
// words while the response side stalls on its own shifting pattern.
// ----------------------------------------------------------------------------
module tb_top;
	import kwm_pkg::*;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam int ITEM_TARGET = 1500;
	localparam int IDLE_LIMIT  = 5000;
	localparam int LONG_HOLD   = 400;

	typedef struct {
		logic signed [VALUE_BITS-1:0] value;
		logic [SRC_BITS-1:0]          source;
		logic [1:0]                   status;
		logic [CNT_BITS-1:0]          occupancy;
	} heap_word_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_EVERY_THIRD, RX_SPARSE} rx_style_t;

	logic clk = 1'b0;
	logic arst_n;

	kwm_cmd_if cmd_ch ();
	kwm_rsp_if rsp_ch ();

	k_way_merge_min_heap_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predicted heap
	entry_t heap_mem [NUM_SOURCES];
	int     heap_fill = 0;

	heap_word_t expected_words [$];
	int         merge_tail [NUM_SOURCES][$];

	int fail_count   = 0;
	int items_sent   = 0;
	int words_seen   = 0;
	int status_seen [4] = '{0, 0, 0, 0};
	int deepest      = 0;
	int merge_runs   = 0;
	int burst_left   = 0;
	int gap_max      = 0;
	int hold_req     = 0;
	int hold_left    = 0;
	int longest_hold = 0;
	int style_left   = 0;
	int rx_tick      = 0;
	int idle_cycles  = 0;
	rx_style_t rx_style = RX_OPEN;

	function automatic bit ranks_first(input entry_t a, input entry_t b);
		if (a.value != b.value)
			return $signed(a.value) < $signed(b.value);
		return a.source < b.source;
	endfunction

	function automatic void swap_slots(input int i, input int j);
		entry_t t;
		t = heap_mem[i];
		heap_mem[i] = heap_mem[j];
		heap_mem[j] = t;
	endfunction

	function automatic void sift_up(input int pos);
		int parent;
		while (pos > 0) begin
			parent = (pos - 1) / 2;
			if (!ranks_first(heap_mem[pos], heap_mem[parent]))
				break;
			swap_slots(pos, parent);
			pos = parent;
		end
	endfunction

	function automatic void sift_down(input int pos);
		int best;
		int l;
		forever begin
			l = 2 * pos + 1;
			best = pos;
			if (l < heap_fill && ranks_first(heap_mem[l], heap_mem[best]))
				best = l;
			if (l + 1 < heap_fill && ranks_first(heap_mem[l + 1], heap_mem[best]))
				best = l + 1;
			if (best == pos)
				break;
			swap_slots(pos, best);
			pos = best;
		end
	endfunction

	function automatic heap_word_t apply_command(input logic [1:0] mode,
			input logic signed [VALUE_BITS-1:0] value, input logic [SRC_BITS-1:0] source);
		heap_word_t w;
		w.value = '0;
		w.source = '0;
		if (mode == MODE_INSERT) begin
			w.source = source;
			if (heap_fill >= NUM_SOURCES) begin
				w.status = ST_FULL;
			end else begin
				heap_mem[heap_fill] = '{value: value, source: source};
				heap_fill++;
				sift_up(heap_fill - 1);
				w.status = ST_INSERTED;
			end
		end else if (heap_fill == 0) begin
			w.status = ST_EMPTY;
		end else begin
			w.value = heap_mem[0].value;
			w.source = heap_mem[0].source;
			w.status = ST_EMITTED;
			if (mode == MODE_REPLACE) begin
				heap_mem[0].value = value;
			end else begin
				heap_fill--;
				heap_mem[0] = heap_mem[heap_fill];
			end
			sift_down(0);
		end
		w.occupancy = CNT_BITS'(heap_fill);
		return w;
	endfunction

	task automatic issue_word(input logic [1:0] mode, input logic signed [VALUE_BITS-1:0] value,
			input logic [SRC_BITS-1:0] source);
		int gap;
		heap_word_t next_word;
		if (burst_left == 0) begin
			if (gap_max > 0) begin
				gap = $urandom_range(1, gap_max);
				@(negedge clk);
				cmd_ch.valid <= 1'b0;
				cmd_ch.mode <= 2'($urandom);
				cmd_ch.value <= $urandom;
				cmd_ch.src <= SRC_BITS'($urandom);
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		cmd_ch.valid <= 1'b1;
		cmd_ch.mode <= mode;
		cmd_ch.value <= value;
		cmd_ch.src <= source;
		do @(posedge clk); while (!cmd_ch.ready);
		next_word = apply_command(mode, value, source);
		expected_words.insert(expected_words.size(), next_word);
		items_sent++;
	endtask

	task automatic settle_queue();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
	endtask

	task automatic flag_field(input string name, input longint want_v, input longint got_v);
		if (want_v != got_v) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
			fail_count++;
		end
	endtask

	// response checker
	always @(posedge clk) begin : check_words
		heap_word_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			words_seen++;
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word, value %0d source %0d status %0d", $time,
					rsp_ch.out_value, rsp_ch.out_source, rsp_ch.status);
				fail_count++;
			end else begin
				want = expected_words.pop_front();
				flag_field("out_value", $signed(want.value), $signed(rsp_ch.out_value));
				flag_field("out_source", want.source, rsp_ch.out_source);
				flag_field("status", want.status, rsp_ch.status);
				flag_field("occupancy", want.occupancy, rsp_ch.occupancy);
				status_seen[want.status]++;
				if (want.occupancy > deepest)
					deepest = want.occupancy;
			end
		end
	end

	// response side stalls
	always @(negedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			if (style_left == 0) begin
				rx_style = rx_style_t'($urandom_range(0, 3));
				style_left = $urandom_range(40, 300);
			end
			style_left--;
			rx_tick = (rx_tick + 1) % 3;
			case (rx_style)
				RX_OPEN:        rsp_ch.ready <= 1'b1;
				RX_COIN:        rsp_ch.ready <= 1'($urandom_range(0, 1));
				RX_EVERY_THIRD: rsp_ch.ready <= (rx_tick != 0);
				default:        rsp_ch.ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic test_directed();
		gap_max = 0;
		issue_word(MODE_POP, 32'sd1, 4'd3);
		issue_word(MODE_REPLACE, 32'sd5, 4'd7);
		issue_word(MODE_SPARE, 32'sd9, 4'd15);
		issue_word(MODE_INSERT, VAL_MAX, 4'd0);
		issue_word(MODE_INSERT, VAL_MIN, 4'd15);
		issue_word(MODE_INSERT, 32'sd0, 4'd5);
		issue_word(MODE_INSERT, -32'sd1, 4'd10);
		issue_word(MODE_INSERT, 32'sd100, 4'd3);
		issue_word(MODE_INSERT, 32'sd100, 4'd2);
		issue_word(MODE_INSERT, 32'sd100, 4'd9);
		issue_word(MODE_INSERT, -32'sd100, 4'd1);
		issue_word(MODE_INSERT, 32'sd42, 4'd4);
		issue_word(MODE_INSERT, 32'sd7, 4'd6);
		issue_word(MODE_INSERT, 32'sd7, 4'd12);
		issue_word(MODE_INSERT, 32'sh4000_0000, 4'd7);
		issue_word(MODE_INSERT, -32'sh4000_0000, 4'd8);
		issue_word(MODE_INSERT, 32'sd1, 4'd11);
		issue_word(MODE_INSERT, -32'sd2, 4'd13);
		issue_word(MODE_INSERT, 32'sd3, 4'd14);
		// heap full: dropped
		issue_word(MODE_INSERT, 32'sd0, 4'd15);
		// replacement keeps the popped source, input source ignored
		issue_word(MODE_REPLACE, VAL_MAX, 4'd0);
		issue_word(MODE_REPLACE, -32'sd100, 4'd0);
		issue_word(MODE_POP, 32'sd0, 4'd0);
		issue_word(MODE_SPARE, 32'sd0, 4'd0);
		issue_word(MODE_POP, 32'sd0, 4'd0);
		settle_queue();
	endtask

	task automatic test_backpressure();
		settle_queue();
		gap_max = 0;
		hold_req = LONG_HOLD;
		longest_hold = LONG_HOLD;
		repeat (20)
			issue_word(($urandom_range(0, 1) == 0) ? MODE_INSERT : MODE_POP, $urandom,
				SRC_BITS'($urandom));
		settle_queue();
	endtask

	task automatic noise_burst(input int count);
		logic [1:0] mode;
		logic signed [VALUE_BITS-1:0] value;
		repeat (count) begin
			case ($urandom_range(0, 7))
				0:       value = VAL_MIN;
				1:       value = VAL_MAX;
				2:       value = $signed($urandom_range(0, 15)) - 8;
				default: value = $urandom;
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: mode = MODE_INSERT;
				5, 6:          mode = MODE_POP;
				7, 8:          mode = MODE_REPLACE;
				default:       mode = MODE_SPARE;
			endcase
			issue_word(mode, value, SRC_BITS'($urandom));
		end
	endtask

	// one sorted run per chosen source (1 to NUM_SOURCES of them), heads in, then the feeder loop
	task automatic run_merge();
		int order [NUM_SOURCES];
		int k;
		int j;
		int t;
		int len;
		int base;
		bit narrow;
		int s;
		for (int i = 0; i < NUM_SOURCES; i++) begin
			order[i] = i;
			merge_tail[i].delete();
		end
		for (int i = NUM_SOURCES - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		k = $urandom_range(1, NUM_SOURCES);
		narrow = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < k; i++) begin
			len = $urandom_range(1, 6);
			base = narrow ? $urandom_range(0, 3) : ($signed($urandom) >>> 2);
			for (int n = 0; n < len; n++) begin
				merge_tail[order[i]].insert(merge_tail[order[i]].size(), base);
				base += narrow ? $urandom_range(0, 1) : $urandom_range(0, 5000);
			end
		end
		for (int i = 0; i < k; i++)
			issue_word(MODE_INSERT, merge_tail[order[i]].pop_front(), SRC_BITS'(order[i]));
		while (heap_fill > 0) begin
			s = heap_mem[0].source;
			if (merge_tail[s].size() > 0)
				issue_word(MODE_REPLACE, merge_tail[s].pop_front(), SRC_BITS'($urandom));
			else
				issue_word(($urandom_range(0, 3) == 0) ? MODE_SPARE : MODE_POP, $urandom,
					SRC_BITS'($urandom));
		end
		merge_runs++;
	endtask

	task automatic test_merge_traffic();
		while (items_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 2))
				0:       gap_max = 0;
				1:       gap_max = 3;
				default: gap_max = 8;
			endcase
			if ($urandom_range(0, 3) == 0)
				noise_burst($urandom_range(10, 40));
			else
				run_merge();
			if ($urandom_range(0, 5) == 0)
				settle_queue();
		end
		settle_queue();
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.mode = MODE_INSERT;
		cmd_ch.value = '0;
		cmd_ch.src = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_backpressure();
		test_merge_traffic();

		repeat (24) @(posedge clk);
		$display("Sent %0d commands over %0d merge runs; %0d response words checked.",
			items_sent, merge_runs, words_seen);
		$display("Emitted %0d, inserted %0d, empty %0d, full %0d; deepest heap %0d, hold-off %0d.",
			status_seen[ST_EMITTED], status_seen[ST_INSERTED], status_seen[ST_EMPTY],
			status_seen[ST_FULL], deepest, longest_hold);
		if (fail_count == 0 && expected_words.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
